### sv/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy block.
package ljpe_pkg;

  // Store depth and its address width.
  localparam int MaxParticles = 256;
  localparam int AddrW        = $clog2(MaxParticles);
  localparam int CountW       = AddrW + 1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BOX_LENGTH    = 2'd0;
  localparam logic [1:0] CFG_SIGMA_LEN     = 2'd1;
  localparam logic [1:0] CFG_EPSILON_DEPTH = 2'd2;

  // Register reset values, Q16.16.
  localparam logic [22:0] BOX_RESET   = 23'd1900544;
  localparam logic [22:0] SIGMA_RESET = 23'd65536;
  localparam logic [31:0] EPS_RESET   = 32'd65536;

  // Saturation limits of the energy sum.
  localparam logic signed [47:0] E_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] E_MIN = 48'sh8000_0000_0000;

  // One input word: a particle position.
  typedef struct packed {
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [21:0] pos_z;
    logic        is_last;
  } ljpe_in_t;

  // One output word: the frame total.
  typedef struct packed {
    logic signed [47:0] total_energy;
    logic [8:0]         particle_total;
    logic               saturated;
  } ljpe_out_t;

endpackage

### sv/ljpe_mul.sv
// Shared 64x64 multiplier built from one 32x32 multiplier, four partial products in turn.
module ljpe_mul import ljpe_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [63:0]   op_a,
  input  logic [63:0]   op_b,
  output logic [127:0]  prod,
  output logic          done
);

  logic [63:0]  a_r, b_r;
  logic [63:0]  pp_r;
  logic [1:0]   sh_r;
  logic [2:0]   step_r;
  logic         busy_r, pv_r, done_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half, b_half;
  logic [127:0] pp_shifted;

  // Pick the halves for this partial product.
  assign a_half = step_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = step_r[0] ? b_r[63:32] : b_r[31:0];

  // Align the registered partial product.
  always_comb begin
    case (sh_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd1:    pp_shifted = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shifted = {pp_r, 64'd0};
      default: pp_shifted = 128'd0;
    endcase
  end

  // One partial product per cycle, added to the sum in the next cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        step_r <= 3'd0;
        a_r    <= op_a;
        b_r    <= op_b;
        acc_r  <= 128'd0;
      end else if (busy_r) begin
        if (pv_r) begin
          acc_r <= acc_r + pp_shifted;
        end
        if (step_r < 3'd4) begin
          pp_r   <= a_half * b_half;
          sh_r   <= 2'({1'b0, step_r[1]} + {1'b0, step_r[0]});
          pv_r   <= 1'b1;
          step_r <= step_r + 3'd1;
        end else begin
          busy_r <= 1'b0;
          pv_r   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

### sv/lennard_jones_pair_energy_top.sv
// Top level of the Lennard-Jones pair energy block: store, sequencer and datapath.
//
// Positions load at one word per cycle while busy is low. A word with is_last
// ends the frame: busy stays high while every pair is visited, and one result
// word appears on out_data for a single cycle with out_valid high; it must be
// taken then, as the block cannot hold it. The shared multiplier gives each pair's
// three squares and, for a pair inside the cutoff, up to four more 64x64 products;
// such a pair may also use the one-bit-per-cycle divider for its 40 quotient bits.
module lennard_jones_pair_energy_top import ljpe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  ljpe_in_t   in_data,
  output logic       out_valid,
  output ljpe_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [31:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_SETL, S_SETS, S_RD, S_WRAP, S_SQX, S_SQY, S_SQZ, S_CUT,
    S_DIV, S_MQ2, S_MQ3, S_MT, S_MMAG, S_ACC, S_NEXT, S_OUT
  } state_t;

  localparam logic [55:0] ONE_Q32 = 56'h1_0000_0000;

  state_t             state_r;
  logic [22:0]        box_r, sig_r;
  logic [31:0]        eps_r;
  logic [CountW-1:0]  cnt_r, n_r, cnt_inc;
  logic [AddrW-1:0]   b_r, c_r;
  logic [65:0]        mem [MaxParticles];
  logic [65:0]        rd0_r, rd1_r;
  logic [45:0]        cut2_r, s2_r;
  logic [47:0]        r2_r;
  logic [22:0]        dy_r, dz_r;
  logic [48:0]        rem_r, trial;
  logic [39:0]        nb_r, quo_r;
  logic [5:0]         dcnt_r;
  logic [55:0]        q3_r;
  logic               pos_r, flag_r;
  logic signed [47:0] term_r, acc_r;
  logic signed [48:0] sum;
  logic               mul_start_r, mul_done;
  logic [63:0]        mul_a_r, mul_b_r;
  logic [127:0]       prod;
  logic               out_valid_r;
  ljpe_out_t          out_data_r;
  logic               accept;
  logic [22:0]        wx, wy, wz;
  logic [63:0]        mag;
  logic [46:0]        mag_clip;

  // Minimum-image axis difference, returned as a magnitude.
  function automatic logic [22:0] wrap_mag(input logic [21:0] a, input logic [21:0] b,
                                           input logic [22:0] len);
    logic signed [26:0] d;
    logic signed [26:0] l;
    logic signed [26:0] nd;
    d = $signed({5'd0, a}) - $signed({5'd0, b});
    l = $signed({4'd0, len});
    if ((d <<< 1) >= l) d = d - l;
    if ((d <<< 1) <= -l) d = d + l;
    nd = -d;
    return d[26] ? nd[22:0] : d[22:0];
  endfunction

  assign accept  = start && (state_r == S_IDLE);
  assign busy    = (state_r != S_IDLE);
  assign cnt_inc = (cnt_r < CountW'(MaxParticles)) ? cnt_r + 1'b1 : cnt_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_RESET;
      sig_r <= SIGMA_RESET;
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BOX_LENGTH:    box_r <= cfg_wdata[22:0];
        CFG_SIGMA_LEN:     sig_r <= cfg_wdata[22:0];
        CFG_EPSILON_DEPTH: eps_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Position store: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (accept && cnt_r < CountW'(MaxParticles)) begin
      mem[cnt_r[AddrW-1:0]] <= {in_data.pos_x, in_data.pos_y, in_data.pos_z};
    end
    rd0_r <= mem[b_r];
    rd1_r <= mem[c_r];
  end

  ljpe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start_r),
    .op_a  (mul_a_r),
    .op_b  (mul_b_r),
    .prod  (prod),
    .done  (mul_done)
  );

  // Axis differences of the current pair.
  assign wx = wrap_mag(rd0_r[65:44], rd1_r[65:44], box_r);
  assign wy = wrap_mag(rd0_r[43:22], rd1_r[43:22], box_r);
  assign wz = wrap_mag(rd0_r[21:0],  rd1_r[21:0],  box_r);

  // Divider step and term shaping.
  assign trial    = {rem_r[47:0], nb_r[39]};
  assign mag      = prod[109:46];
  assign mag_clip = (mag[63:47] != 17'd0) ? E_MAX[46:0] : mag[46:0];
  assign sum      = {acc_r[47], acc_r} + {term_r[47], term_r};

  // Pair sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.is_last) begin
              n_r         <= cnt_inc;
              cnt_r       <= '0;
              acc_r       <= '0;
              flag_r      <= 1'b0;
              mul_a_r     <= {41'd0, box_r};
              mul_b_r     <= {41'd0, box_r};
              mul_start_r <= 1'b1;
              state_r     <= S_SETL;
            end else begin
              cnt_r <= cnt_inc;
            end
          end
        end
        S_SETL: begin
          if (mul_done) begin
            cut2_r      <= prod[45:0];
            mul_a_r     <= {41'd0, sig_r};
            mul_b_r     <= {41'd0, sig_r};
            mul_start_r <= 1'b1;
            state_r     <= S_SETS;
          end
        end
        S_SETS: begin
          if (mul_done) begin
            s2_r <= prod[45:0];
            b_r  <= '0;
            c_r  <= AddrW'(1);
            state_r <= (n_r < CountW'(2)) ? S_OUT : S_RD;
          end
        end
        S_RD: begin
          state_r <= S_WRAP;
        end
        S_WRAP: begin
          dy_r        <= wy;
          dz_r        <= wz;
          r2_r        <= '0;
          mul_a_r     <= {41'd0, wx};
          mul_b_r     <= {41'd0, wx};
          mul_start_r <= 1'b1;
          state_r     <= S_SQX;
        end
        S_SQX: begin
          if (mul_done) begin
            r2_r        <= r2_r + prod[47:0];
            mul_a_r     <= {41'd0, dy_r};
            mul_b_r     <= {41'd0, dy_r};
            mul_start_r <= 1'b1;
            state_r     <= S_SQY;
          end
        end
        S_SQY: begin
          if (mul_done) begin
            r2_r        <= r2_r + prod[47:0];
            mul_a_r     <= {41'd0, dz_r};
            mul_b_r     <= {41'd0, dz_r};
            mul_start_r <= 1'b1;
            state_r     <= S_SQZ;
          end
        end
        S_SQZ: begin
          if (mul_done) begin
            r2_r    <= r2_r + prod[47:0];
            state_r <= S_CUT;
          end
        end
        S_CUT: begin
          // Cutoff test, coincident pair, and quotient range check.
          if ({r2_r, 2'b00} >= {4'd0, cut2_r}) begin
            state_r <= S_NEXT;
          end else if (r2_r == 48'd0) begin
            acc_r   <= E_MAX;
            flag_r  <= 1'b1;
            state_r <= S_OUT;
          end else if ({11'd0, s2_r} >= {1'b0, r2_r, 8'd0}) begin
            if (eps_r != 32'd0) begin
              acc_r   <= E_MAX;
              flag_r  <= 1'b1;
              state_r <= S_OUT;
            end else begin
              state_r <= S_NEXT;
            end
          end else begin
            rem_r   <= {11'd0, s2_r[45:8]};
            nb_r    <= {s2_r[7:0], 32'd0};
            quo_r   <= '0;
            dcnt_r  <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle.
          if (dcnt_r < 6'd40) begin
            if (trial >= {1'b0, r2_r}) begin
              rem_r <= trial - {1'b0, r2_r};
              quo_r <= {quo_r[38:0], 1'b1};
            end else begin
              rem_r <= trial;
              quo_r <= {quo_r[38:0], 1'b0};
            end
            nb_r   <= {nb_r[38:0], 1'b0};
            dcnt_r <= dcnt_r + 6'd1;
          end else begin
            mul_a_r     <= {24'd0, quo_r};
            mul_b_r     <= {24'd0, quo_r};
            mul_start_r <= 1'b1;
            state_r     <= S_MQ2;
          end
        end
        S_MQ2: begin
          if (mul_done) begin
            mul_a_r     <= {16'd0, prod[79:32]};
            mul_b_r     <= {24'd0, quo_r};
            mul_start_r <= 1'b1;
            state_r     <= S_MQ3;
          end
        end
        S_MQ3: begin
          if (mul_done) begin
            q3_r        <= prod[87:32];
            mul_a_r     <= {32'd0, eps_r};
            mul_b_r     <= {8'd0, prod[87:32]};
            mul_start_r <= 1'b1;
            state_r     <= S_MT;
          end
        end
        S_MT: begin
          if (mul_done) begin
            if (prod[127:80] != 48'd0) begin
              acc_r   <= E_MAX;
              flag_r  <= 1'b1;
              state_r <= S_OUT;
            end else begin
              pos_r       <= (q3_r >= ONE_Q32);
              mul_a_r     <= prod[79:16];
              mul_b_r     <= (q3_r >= ONE_Q32) ? {8'd0, q3_r - ONE_Q32}
                                               : {8'd0, ONE_Q32 - q3_r};
              mul_start_r <= 1'b1;
              state_r     <= S_MMAG;
            end
          end
        end
        S_MMAG: begin
          if (mul_done) begin
            if (pos_r) begin
              if (prod[127:110] != 18'd0 || mag[63:47] != 17'd0) begin
                acc_r   <= E_MAX;
                flag_r  <= 1'b1;
                state_r <= S_OUT;
              end else begin
                term_r  <= $signed({1'b0, mag[46:0]});
                state_r <= S_ACC;
              end
            end else begin
              term_r  <= -$signed({1'b0, mag_clip});
              state_r <= S_ACC;
            end
          end
        end
        S_ACC: begin
          // Saturating add of the pair term.
          if (!sum[48] && sum[47]) begin
            acc_r  <= E_MAX;
            flag_r <= 1'b1;
          end else if (sum[48] && !sum[47]) begin
            acc_r  <= E_MIN;
            flag_r <= 1'b1;
          end else begin
            acc_r <= sum[47:0];
          end
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          // Step to the next unordered pair.
          if ({1'b0, c_r} + 1'b1 < n_r) begin
            c_r     <= c_r + 1'b1;
            state_r <= S_RD;
          end else if ({1'b0, b_r} + CountW'(2) < n_r) begin
            b_r     <= b_r + 1'b1;
            c_r     <= b_r + AddrW'(2);
            state_r <= S_RD;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid_r                <= 1'b1;
          out_data_r.total_energy    <= acc_r;
          out_data_r.particle_total  <= n_r;
          out_data_r.saturated       <= flag_r;
          state_r                    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/ljpe_checker.sv
// Checker for the Lennard-Jones pair energy block: predicts each frame total and compares.
`timescale 1ns / 100ps

module ljpe_checker import ljpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  ljpe_in_t    in_data,
  input  logic        out_valid,
  input  ljpe_out_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);

  localparam int FifoDepth = 4;

  // Shadow copy of the registers and the position stores.
  logic [22:0] box_q;
  logic [22:0] sigma_q;
  logic [31:0] eps_q;
  logic [21:0] xs [MaxParticles];
  logic [21:0] ys [MaxParticles];
  logic [21:0] zs [MaxParticles];
  int          frame_count;
  ljpe_out_t   frame_totals [FifoDepth];
  int          wr_idx;
  int          rd_idx;

  // Minimum-image difference along one axis.
  function automatic longint min_image(input logic [21:0] a, input logic [21:0] b);
    longint d;
    longint side;
    d = longint'(a) - longint'(b);
    side = longint'(box_q);
    if (2 * d >= side) d -= side;
    if (2 * d <= -side) d += side;
    return d;
  endfunction

  // Energy of one pair inside the cutoff. Returns 1 when the pair pins the total.
  function automatic bit pair_energy(input logic [63:0] r2, output longint term);
    logic [63:0]  s2;
    logic [63:0]  q;
    logic [63:0]  q2;
    logic [63:0]  q3;
    logic [63:0]  t;
    logic [63:0]  d;
    logic [63:0]  mag;
    logic [127:0] p;
    term = 0;
    s2 = 64'(sigma_q) * 64'(sigma_q);
    if (r2 == 0) return 1'b1;
    if (s2 / r2 >= 64'd256) return eps_q != 0;
    p = (128'(s2) << 32) / 128'(r2);
    q = p[63:0];
    p = 128'(q) * 128'(q);
    q2 = p[95:32];
    p = 128'(q2) * 128'(q);
    q3 = p[95:32];
    p = 128'(eps_q) * 128'(q3);
    t = p[79:16];
    if (p[127:80] != 0) return 1'b1;
    if (q3 >= 64'h1_0000_0000) begin
      d = q3 - 64'h1_0000_0000;
      p = 128'(t) * 128'(d);
      mag = p[109:46];
      if (p[127:110] != 0 || mag > 64'(E_MAX)) return 1'b1;
      term = longint'(mag);
    end else begin
      d = 64'h1_0000_0000 - q3;
      p = 128'(t) * 128'(d);
      mag = p[109:46];
      if (mag > 64'(E_MAX)) mag = 64'(E_MAX);
      term = -longint'(mag);
    end
    return 1'b0;
  endfunction

  // Sum over all unordered pairs of the loaded frame.
  function automatic ljpe_out_t frame_energy(input int n);
    ljpe_out_t   res;
    longint      acc;
    longint      term;
    longint      dx;
    longint      dy;
    longint      dz;
    logic [63:0] r2;
    logic [63:0] cut2;
    bit          pinned;
    bit          flag;
    acc = 0;
    pinned = 1'b0;
    flag = 1'b0;
    cut2 = 64'(box_q) * 64'(box_q);
    for (int b = 0; b + 1 < n && !pinned; b++) begin
      for (int c = b + 1; c < n && !pinned; c++) begin
        dx = min_image(xs[b], xs[c]);
        dy = min_image(ys[b], ys[c]);
        dz = min_image(zs[b], zs[c]);
        r2 = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
        if (4 * r2 < cut2) begin
          if (pair_energy(r2, term)) begin
            pinned = 1'b1;
          end else begin
            acc = acc + term;
            if (acc > longint'(E_MAX)) begin
              acc = longint'(E_MAX);
              flag = 1'b1;
            end
            if (acc < longint'(E_MIN)) begin
              acc = longint'(E_MIN);
              flag = 1'b1;
            end
          end
        end
      end
    end
    if (pinned) begin
      acc = longint'(E_MAX);
      flag = 1'b1;
    end
    res.total_energy = acc[47:0];
    res.particle_total = 9'(n);
    res.saturated = flag;
    return res;
  endfunction

  assign pending = wr_idx - rd_idx;

  // Follow register writes, input words and result words.
  always @(posedge clk) begin
    ljpe_out_t want;
    if (!rst_n) begin
      box_q <= BOX_RESET;
      sigma_q <= SIGMA_RESET;
      eps_q <= EPS_RESET;
      frame_count = 0;
      errors = 0;
      wr_idx = 0;
      rd_idx = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_BOX_LENGTH:    box_q <= cfg_wdata[22:0];
          CFG_SIGMA_LEN:     sigma_q <= cfg_wdata[22:0];
          CFG_EPSILON_DEPTH: eps_q <= cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (frame_count < MaxParticles) begin
          xs[frame_count] = in_data.pos_x;
          ys[frame_count] = in_data.pos_y;
          zs[frame_count] = in_data.pos_z;
          frame_count++;
        end
        if (in_data.is_last) begin
          frame_totals[wr_idx % FifoDepth] = frame_energy(frame_count);
          wr_idx++;
          frame_count = 0;
        end
      end
      if (out_valid) begin
        if (wr_idx == rd_idx) begin
          $display("%0t: unexpected result word %h", $time, out_data);
          errors = errors + 1;
        end else begin
          want = frame_totals[rd_idx % FifoDepth];
          rd_idx++;
          if (want.total_energy !== out_data.total_energy) begin
            $display("%0t: total_energy expected %0d actual %0d", $time,
                     want.total_energy, out_data.total_energy);
            errors = errors + 1;
          end
          if (want.particle_total !== out_data.particle_total) begin
            $display("%0t: particle_total expected %0d actual %0d", $time,
                     want.particle_total, out_data.particle_total);
            errors = errors + 1;
          end
          if (want.saturated !== out_data.saturated) begin
            $display("%0t: saturated expected %0d actual %0d", $time,
                     want.saturated, out_data.saturated);
            errors = errors + 1;
          end
        end
      end
    end
  end

endmodule

### verif/testbench.sv
// Top of the Lennard-Jones pair energy testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench import ljpe_pkg::*; ();

  localparam int IdleLimit = 4000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  ljpe_in_t    in_data;
  logic        out_valid;
  ljpe_out_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [31:0] cfg_wdata;
  int          errors;
  int          pending;
  int          idle_cycles;
  int          words_sent;
  logic [22:0] box_now;
  logic [22:0] sigma_now;

  lennard_jones_pair_energy_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  ljpe_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Random pause, mostly short, sometimes long, often none.
  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    repeat (n) @(negedge clk);
  endtask

  // Present one position word and hold it until the block takes it.
  task automatic send_word(input logic [21:0] x, input logic [21:0] y,
                           input logic [21:0] z, input logic last);
    in_data.pos_x = x;
    in_data.pos_y = y;
    in_data.pos_z = z;
    in_data.is_last = last;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    @(negedge clk);
    start = 1'b0;
    idle_gap();
  endtask

  // Let every expected frame total arrive before touching the registers.
  task automatic settle();
    while (pending != 0 || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    if (idx == CFG_BOX_LENGTH) box_now = val[22:0];
    if (idx == CFG_SIGMA_LEN) sigma_now = val[22:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // A frame of n particles; clustered positions put many pairs inside the cutoff.
  task automatic random_frame(input int n, input bit noisy);
    logic [21:0] x;
    logic [21:0] y;
    logic [21:0] z;
    int          spread;
    spread = (sigma_now > 23'd1000000) ? 1000000 : int'(sigma_now) * 2 + 1;
    x = 22'($urandom_range(0, box_now > 0 ? int'(box_now) - 1 : 0));
    y = 22'($urandom_range(0, box_now > 0 ? int'(box_now) - 1 : 0));
    z = 22'($urandom_range(0, box_now > 0 ? int'(box_now) - 1 : 0));
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(0, 3) == 0) begin
        send_word(22'($urandom), 22'($urandom), 22'($urandom), k == n - 1);
      end else begin
        send_word(x + 22'($urandom_range(0, spread)), y + 22'($urandom_range(0, spread)),
                  z + 22'($urandom_range(0, spread)), k == n - 1);
      end
    end
  endtask

  // Pick a register setting from the extremes or at random.
  task automatic random_setting();
    case ($urandom_range(0, 3))
      0: write_reg(CFG_BOX_LENGTH, 32'd65536);
      1: write_reg(CFG_BOX_LENGTH, 32'd4194304);
      default: write_reg(CFG_BOX_LENGTH, $urandom_range(65536, 4194304));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(CFG_SIGMA_LEN, 32'd1);
      1: write_reg(CFG_SIGMA_LEN, 32'd4194304);
      default: write_reg(CFG_SIGMA_LEN, $urandom_range(1, int'(box_now) / 4 + 1));
    endcase
    case ($urandom_range(0, 5))
      0: write_reg(CFG_EPSILON_DEPTH, 32'd0);
      1: write_reg(CFG_EPSILON_DEPTH, 32'hFFFF_FFFF);
      default: write_reg(CFG_EPSILON_DEPTH, $urandom_range(1, 32'h0100_0000));
    endcase
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_BOX_LENGTH;
    cfg_wdata = '0;
    words_sent = 0;
    box_now = BOX_RESET;
    sigma_now = SIGMA_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: a pair near the well bottom, then a lone particle.
    send_word(22'd0, 22'd0, 22'd0, 1'b0);
    send_word(22'd73400, 22'd0, 22'd0, 1'b1);
    send_word(22'd5000, 22'd5000, 22'd5000, 1'b1);
    // Coincident pair, and a pair wrapped across the box edge.
    send_word(22'd100, 22'd200, 22'd300, 1'b0);
    send_word(22'd100, 22'd200, 22'd300, 1'b1);
    send_word(22'd1000, 22'd0, 22'd0, 1'b0);
    send_word(22'd1850000, 22'd0, 22'd0, 1'b1);
    settle();
    // Zero well depth with a very close pair; positions beyond the box.
    write_reg(CFG_EPSILON_DEPTH, 32'd0);
    write_reg(CFG_BOX_LENGTH, 32'd65536);
    send_word(22'd0, 22'd0, 22'd0, 1'b0);
    send_word(22'd10, 22'd0, 22'd0, 1'b0);
    send_word(22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF, 1'b1);
    settle();
    // Largest well depth and sigma: huge terms and a saturated sum.
    write_reg(CFG_EPSILON_DEPTH, 32'hFFFF_FFFF);
    write_reg(CFG_BOX_LENGTH, 32'd4194304);
    write_reg(CFG_SIGMA_LEN, 32'd4194304);
    send_word(22'd0, 22'd0, 22'd0, 1'b0);
    send_word(22'd1200000, 22'd0, 22'd0, 1'b0);
    send_word(22'd0, 22'd1200000, 22'd0, 1'b0);
    send_word(22'd0, 22'd0, 22'd1200000, 1'b1);
    settle();
    // Smallest sigma: negligible attraction.
    write_reg(CFG_SIGMA_LEN, 32'd1);
    send_word(22'd0, 22'd0, 22'd0, 1'b0);
    send_word(22'd1, 22'd0, 22'd0, 1'b1);
    settle();
    // Zero box: no pair within the cutoff, and one frame that overfills the store.
    write_reg(CFG_BOX_LENGTH, 32'd0);
    for (int k = 0; k <= MaxParticles; k++) begin
      send_word(22'($urandom), 22'($urandom), 22'($urandom), k == MaxParticles);
    end
    settle();
    write_reg(CFG_SIGMA_LEN, 32'd65536);
    write_reg(CFG_EPSILON_DEPTH, 32'd65536);
    write_reg(CFG_BOX_LENGTH, 32'd1900544);

    // Random frames, mostly clustered, some with raw noise positions.
    while (words_sent < 550) begin
      if ($urandom_range(0, 3) == 0) begin
        settle();
        random_setting();
      end
      if ($urandom_range(0, 15) == 0) random_frame($urandom_range(14, 24), 1'b1);
      else random_frame($urandom_range(1, 8), $urandom_range(0, 4) == 0);
    end

    settle();
    repeat (200) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
